// ----- rtl/bounded_deque_assert.svh -----
`ifndef BOUNDED_DEQUE_ASSERT_SVH
`define BOUNDED_DEQUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bounded_deque: check failed");

// Next-cycle implication, checked out of reset.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bounded_deque: check failed");

`endif

// ----- rtl/bdq_pkg.sv -----
package bdq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int VW    = 32;
    localparam int CAPW  = 5;
    localparam int EW    = (CW > CAPW) ? CW : CAPW;

    localparam logic [CAPW-1:0] CAP_RESET = CAPW'(10);
    localparam logic [AW:0]     DEPTH_W   = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]   LAST_POS  = AW'(DEPTH - 1);

    // tdata layouts, lowest bit first
    localparam int IN_W  = 40;  // action[1:0], value[33:2], zero fill
    localparam int OUT_W = 72;  // ok[0], count[5:1], front[37:6], back[69:38], zero fill

    typedef enum logic [1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

    // (pos + off) modulo DEPTH, both below DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] pos,
                                               input logic [AW-1:0] off);
        logic [AW:0] p;
        p = {1'b0, pos} + {1'b0, off};
        if (p >= DEPTH_W) begin
            p = p - DEPTH_W;
        end
        return p[AW-1:0];
    endfunction

endpackage

// ----- rtl/bounded_deque.sv -----
// Channel   Dir  Fields (tdata, lowest bit up)
// s_axis    in   action[1:0], value[33:2]
// m_axis    out  ok[0], count[5:1], front_value[37:6], back_value[69:38]
// cfg       in   capacity[4:0], write on i_cfg_we
//
// Each operation passes through ST_IDLE and ST_READ: the accept cycle updates
// head/count, writes the pushed value and reads the new front and back entries
// from the ring RAM; as the RAM read is registered, ST_READ then loads the result
// register once the output is free. Output stall holds the block in the read state;
// one item may be taken while the previous result waits. Synchronous active-low reset
// clears head, count, capacity (to 10) and the handshake state; RAM is not cleared.
module bounded_deque
    import bdq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAPW-1:0]  i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // action[1:0], value[33:2]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // ok, count[4:0], front[31:0], back[31:0]
);

    logic [VW-1:0]    mem [DEPTH];

    t_state           r_state;
    logic [CAPW-1:0]  r_cap;
    logic [AW-1:0]    r_head;
    logic [CW-1:0]    r_count;
    logic             r_ok;
    logic [VW-1:0]    r_rd_front;
    logic [VW-1:0]    r_rd_back;
    logic             r_fwd_front;
    logic             r_fwd_back;
    logic [VW-1:0]    r_wdata;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    t_action          action;
    logic [VW-1:0]    value;
    logic             acc;
    logic             load_out;
    logic [EW-1:0]    cap_eff;
    logic             full;
    logic             ok;
    logic             we;
    logic [AW-1:0]    wa;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    n_count;
    logic [AW-1:0]    back_off;
    logic [AW-1:0]    ra_front;
    logic [AW-1:0]    ra_back;
    logic [VW-1:0]    front_val;
    logic [VW-1:0]    back_val;

    assign action = t_action'(s_axis_tdata[1:0]);
    assign value  = s_axis_tdata[VW+1:2];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign load_out      = (r_state == ST_READ) && (!r_out_valid || m_axis_tready);

    always_comb begin
        cap_eff = EW'(r_cap);
        if (cap_eff == '0) begin
            cap_eff = EW'(1);
        end
        if (cap_eff > EW'(DEPTH)) begin
            cap_eff = EW'(DEPTH);
        end
        full = (EW'(r_count) >= cap_eff);

        ok      = 1'b0;
        we      = 1'b0;
        wa      = ring_add(r_head, r_count[AW-1:0]);
        n_head  = r_head;
        n_count = r_count;
        case (action)
            ACT_PUSH_BACK: begin
                if (!full) begin
                    ok      = 1'b1;
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_PUSH_FRONT: begin
                if (!full) begin
                    ok      = 1'b1;
                    we      = 1'b1;
                    n_head  = (r_head == '0) ? LAST_POS : r_head - AW'(1);
                    wa      = n_head;
                    n_count = r_count + CW'(1);
                end
            end
            ACT_POP_FRONT: begin
                if (r_count != '0) begin
                    ok      = 1'b1;
                    n_head  = ring_add(r_head, AW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            ACT_POP_BACK: begin
                if (r_count != '0) begin
                    ok      = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        back_off = (n_count == '0) ? '0 : AW'(n_count - CW'(1));
        ra_front = n_head;
        ra_back  = ring_add(n_head, back_off);
    end

    // ring RAM: one write, two registered reads; read-during-write is forwarded
    always_ff @(posedge i_clk) begin
        if (acc && we) begin
            mem[wa] <= value;
        end
        if (acc) begin
            r_rd_front  <= mem[ra_front];
            r_rd_back   <= mem[ra_back];
            r_fwd_front <= we && (ra_front == wa);
            r_fwd_back  <= we && (ra_back == wa);
            r_wdata     <= value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cap   <= CAP_RESET;
            r_head  <= '0;
            r_count <= '0;
            r_ok    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (acc) begin
                        r_head  <= n_head;
                        r_count <= n_count;
                        r_ok    <= ok;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        front_val = r_fwd_front ? r_wdata : r_rd_front;
        back_val  = r_fwd_back  ? r_wdata : r_rd_back;
        if (r_count == '0) begin
            front_val = '0;
            back_val  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= OUT_W'({back_val, front_val, r_count, r_ok});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/bdq_checker.sv -----
`include "bounded_deque_assert.svh"

module bdq_checker
    import bdq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic           in_beat;
    logic [CW-1:0]  out_count;
    logic [VW-1:0]  out_front;
    logic [VW-1:0]  out_back;

    assign in_beat   = s_axis_tvalid && s_axis_tready;
    assign out_count = m_axis_tdata[CW:1];
    assign out_front = m_axis_tdata[CW+VW:CW+1];
    assign out_back  = m_axis_tdata[CW+2*VW:CW+VW+1];

    // held result stays put
    `BDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

    // one operation in flight: no beat right after a beat
    `BDQ_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_beat, !s_axis_tready)

    `BDQ_ASSERT_NOW(a_count_range, i_clk, i_rst_n, m_axis_tvalid,
        out_count <= CW'(DEPTH))

    // empty queue shows zero at both ends
    `BDQ_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, m_axis_tvalid && (out_count == '0),
        (out_front == '0) && (out_back == '0))

    // a single entry is both front and back
    `BDQ_ASSERT_NOW(a_single_same, i_clk, i_rst_n, m_axis_tvalid && (out_count == CW'(1)),
        out_front == out_back)

endmodule

bind bounded_deque bdq_checker u_bdq_checker (.*);

// ----- dv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    // ok, count, front, back (same order as the m_axis tdata fields, high to low here)
    typedef struct packed {
        logic        ok;
        logic [4:0]  count;
        logic [31:0] front;
        logic [31:0] back;
    } t_deque_result;

    typedef struct {
        bit              is_cap;
        logic [CAPW-1:0] cap;
        t_action         act;
        logic [31:0]     val;
        bit              typed;
        t_deque_result   res;
    } t_stim_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [CAPW-1:0]  i_cfg_wdata = '0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    wire  [OUT_W-1:0] m_axis_tdata;

    // deque mirror
    logic [31:0]     ring_mem [DEPTH];
    int              ring_head;
    int              ring_count;
    logic [CAPW-1:0] cap_reg;

    t_deque_result pending_results [$];
    t_stim_row     stim_rows [$];
    int            err_cnt = 0;

    t_deque_result mon_got;
    t_deque_result mon_want;

    int rx_wait = 0;
    int rx_beats = 0;
    bit rx_calm = 1'b0;

    bounded_deque dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_deque_result deque_apply(input t_action act, input logic [31:0] val);
        int            lim;
        t_deque_result r;
        lim = (cap_reg == '0) ? 1 : ((int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg));
        r.ok = 1'b0;
        case (act)
            ACT_PUSH_BACK: begin
                if (ring_count < lim) begin
                    ring_mem[(ring_head + ring_count) % DEPTH] = val;
                    ring_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_PUSH_FRONT: begin
                if (ring_count < lim) begin
                    ring_head = (ring_head + DEPTH - 1) % DEPTH;
                    ring_mem[ring_head] = val;
                    ring_count++;
                    r.ok = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (ring_count > 0) begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                    r.ok = 1'b1;
                end
            end
            default: begin
                if (ring_count > 0) begin
                    ring_count--;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.count = 5'(ring_count);
        if (ring_count > 0) begin
            r.front = ring_mem[ring_head];
            r.back  = ring_mem[(ring_head + ring_count - 1) % DEPTH];
        end else begin
            r.front = '0;
            r.back  = '0;
        end
        return r;
    endfunction

    function automatic void add_op(input t_action act, input logic [31:0] val);
        t_stim_row row;
        row.is_cap = 1'b0;
        row.cap    = '0;
        row.act    = act;
        row.val    = val;
        row.typed  = 1'b0;
        row.res    = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_chk(input t_action act, input logic [31:0] val,
                                    input t_deque_result res);
        t_stim_row row;
        row.is_cap = 1'b0;
        row.cap    = '0;
        row.act    = act;
        row.val    = val;
        row.typed  = 1'b1;
        row.res    = res;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cap(input logic [CAPW-1:0] v);
        t_stim_row row;
        row.is_cap = 1'b1;
        row.cap    = v;
        row.act    = ACT_PUSH_BACK;
        row.val    = '0;
        row.typed  = 1'b0;
        row.res    = '0;
        stim_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 40) begin
            $display("ERROR %0t: %s", $time, msg);
        end
    endtask

    // caller drops tvalid first; the extra cycles cover the result register
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAPW-1:0] v);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cap_reg = v;
    endtask

    task automatic send_op(input t_action act, input logic [31:0] val, input bit typed,
                           input t_deque_result typed_res, input int gap);
        t_deque_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({val, act});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        // beat taken at this edge
        predicted = deque_apply(act, val);
        pending_results.push_back(typed ? typed_res : predicted);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result sink with random stalls, redrawn per beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_beats++;
            if (rx_beats % 64 == 0) begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            rx_wait = rx_calm ? 0 : $urandom_range(0, 10);
            m_axis_tready <= (rx_wait == 0);
        end else if (!m_axis_tready) begin
            if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_wait == 0) begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mon_got = {m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[37:6],
                       m_axis_tdata[69:38]};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending: %h", m_axis_tdata));
            end else begin
                mon_want = pending_results.pop_front();
                if (mon_got.ok !== mon_want.ok)
                    report_mismatch($sformatf("ok %b, want %b", mon_got.ok, mon_want.ok));
                if (mon_got.count !== mon_want.count)
                    report_mismatch($sformatf("count %0d, want %0d",
                                              mon_got.count, mon_want.count));
                if (mon_got.front !== mon_want.front)
                    report_mismatch($sformatf("front %h, want %h",
                                              mon_got.front, mon_want.front));
                if (mon_got.back !== mon_want.back)
                    report_mismatch($sformatf("back %h, want %h",
                                              mon_got.back, mon_want.back));
            end
        end
    end

    initial begin
        int          cap_seq [8];
        t_action     act;
        logic [31:0] val;
        logic [31:0] edge_vals [4];
        bit          tx_calm;
        bit          push_heavy;
        bit          is_push;
        int          roll;

        cap_seq   = '{1, 0, 16, 31, 17, 2, 15, 10};
        edge_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};

        for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;
        ring_head  = 0;
        ring_count = 0;
        cap_reg    = CAP_RESET;

        // empty removals, extremes, fill to the reset capacity, overfill,
        // capacity below count, capacity 0 and above the depth
        add_chk(ACT_POP_FRONT, 32'h1234_5678, '0);
        add_chk(ACT_POP_BACK, 32'hFFFF_FFFF, '0);
        add_chk(ACT_PUSH_BACK, 32'h7FFF_FFFF, {1'b1, 5'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        add_chk(ACT_PUSH_FRONT, 32'h8000_0000, {1'b1, 5'd2, 32'h8000_0000, 32'h7FFF_FFFF});
        add_chk(ACT_POP_BACK, 32'h0, {1'b1, 5'd1, 32'h8000_0000, 32'h8000_0000});
        add_chk(ACT_POP_FRONT, 32'h0, {1'b1, 5'd0, 32'h0000_0000, 32'h0000_0000});
        add_op(ACT_PUSH_BACK, 32'h0000_0000);
        add_op(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        add_op(ACT_PUSH_BACK, 32'h5555_5555);
        add_op(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
        add_op(ACT_PUSH_BACK, 32'h0000_0001);
        add_op(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        add_op(ACT_PUSH_BACK, 32'h8000_0000);
        add_op(ACT_PUSH_FRONT, 32'h0000_FFFF);
        add_op(ACT_PUSH_BACK, 32'hFFFF_0000);
        add_op(ACT_PUSH_FRONT, 32'h1357_9BDF);
        add_op(ACT_PUSH_BACK, 32'hDEAD_0001);
        add_op(ACT_PUSH_FRONT, 32'hDEAD_0002);
        add_cap(5'd4);
        add_op(ACT_PUSH_BACK, 32'h0BAD_0003);
        add_op(ACT_POP_FRONT, 32'h0);
        add_op(ACT_POP_BACK, 32'h0);
        add_cap(5'd0);
        add_op(ACT_PUSH_FRONT, 32'h0BAD_0004);
        add_cap(5'd17);
        add_op(ACT_PUSH_BACK, 32'h2468_ACE0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cap) begin
                write_capacity(stim_rows[i].cap);
            end else begin
                send_op(stim_rows[i].act, stim_rows[i].val, stim_rows[i].typed,
                        stim_rows[i].res, $urandom_range(0, 10));
            end
        end

        for (int ph = 0; ph < 16; ph++) begin
            write_capacity((ph < 8) ? CAPW'(cap_seq[ph]) : CAPW'($urandom_range(0, 31)));
            tx_calm = (ph % 4 == 3);
            for (int k = 0; k < 50; k++) begin
                if (ph == 5 && k == 25) begin
                    // hold off until the pipe is empty
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                // alternate fill-heavy and drain-heavy stretches to hit full and empty
                push_heavy = ((k / 20) % 2 == 0);
                roll = $urandom_range(0, 99);
                is_push = push_heavy ? (roll < 85) : (roll < 15);
                if (is_push)
                    act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
                else
                    act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
                if ($urandom_range(0, 7) == 0)
                    val = edge_vals[$urandom_range(0, 3)];
                else
                    val = $urandom;
                send_op(act, val, 1'b0, '0, tx_calm ? 0 : $urandom_range(0, 10));
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
